// ----- rtl/lsh_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Laplacian sharpening package
// Shared constants, register indexes and types of the 3x3 sharpening filter.
// ----------------------------------------------------------------------------
package lsh_pkg;

    localparam int CHAN_W           = 8;
    localparam int CFG_W            = 12;
    localparam int CFG_IDX_W        = 4;
    localparam int ROW_W            = 12;
    localparam int CHAN_CNT_W       = 2;
    localparam int PORT_LANES       = 3;
    localparam int MAX_HEIGHT       = 2048;
    localparam int DEF_MAX_WIDTH    = 2048;
    localparam int DEF_MAX_CHANNELS = 3;
    localparam int OQ_DEPTH         = 8;
    localparam int OQ_PTR_W         = $clog2(OQ_DEPTH);
    localparam int OQ_LVL_W         = $clog2(OQ_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 4'd2;

    localparam logic [CFG_W-1:0]      RST_IMAGE_WIDTH   = 12'd640;
    localparam logic [CFG_W-1:0]      RST_IMAGE_HEIGHT  = 12'd480;
    localparam logic [CHAN_CNT_W-1:0] RST_CHANNEL_COUNT = 2'd3;

    typedef struct packed {
        logic [CHAN_W-1:0] sharp_chan_a;
        logic [CHAN_W-1:0] sharp_chan_b;
        logic [CHAN_W-1:0] sharp_chan_c;
        logic              row_end;
        logic              frame_end;
    } lsh_item_t;

    typedef struct packed {
        logic push_a;
        logic push_b;
    } lsh_push_t;

    typedef struct packed {
        logic valid;
        logic emit_a;
        logic emit_b;
        logic interior;
        logic frame_end;
    } lsh_stage_t;

endpackage

`default_nettype wire

// ----- rtl/lsh_ifs.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Laplacian sharpening channel interfaces
// Pixel input, sharpened output and register write channels.
// ----------------------------------------------------------------------------
interface lsh_pix_if;
    logic                      valid;
    logic                      ready;
    logic [lsh_pkg::CHAN_W-1:0] pixel_chan_a;
    logic [lsh_pkg::CHAN_W-1:0] pixel_chan_b;
    logic [lsh_pkg::CHAN_W-1:0] pixel_chan_c;

    modport source (output valid, output pixel_chan_a, output pixel_chan_b,
                    output pixel_chan_c, input ready);
    modport sink (input valid, input pixel_chan_a, input pixel_chan_b,
                  input pixel_chan_c, output ready);
endinterface

interface lsh_out_if;
    logic                      valid;
    logic                      ready;
    logic [lsh_pkg::CHAN_W-1:0] sharp_chan_a;
    logic [lsh_pkg::CHAN_W-1:0] sharp_chan_b;
    logic [lsh_pkg::CHAN_W-1:0] sharp_chan_c;
    logic                      row_end;
    logic                      frame_end;

    modport source (output valid, output sharp_chan_a, output sharp_chan_b,
                    output sharp_chan_c, output row_end, output frame_end,
                    input ready);
    modport sink (input valid, input sharp_chan_a, input sharp_chan_b,
                  input sharp_chan_c, input row_end, input frame_end,
                  output ready);
endinterface

interface lsh_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [lsh_pkg::CFG_IDX_W-1:0] index;
    logic [lsh_pkg::CFG_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/laplacian_sharpen_3x3_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Laplacian sharpening filter, 3x3, top level
// Streams raster pixels through two line buffers and one kernel lane per
// channel; results wait in a small queue toward the output channel.
//
//   Channel    Dir  Payload                                        Each request
//   pix_in     in   pixel_chan_a/b/c                               one pixel
//   sharp_out  out  sharp_chan_a/b/c, row_end, frame_end           one pixel
//   cfg        in   index, data                                    one write
//
// One pixel is accepted per clock while the output queue has room; its results
// pass a registered stage before they enter the queue. The line memory takes
// one read and one write per cycle, which sets the rate of one pixel per clock.
// The line memory is not cleared after reset; its old contents never reach
// an interior result. Input is held back only while the eight-entry output
// queue lacks room for the results still in flight.
// ----------------------------------------------------------------------------
module laplacian_sharpen_3x3_top #(
    parameter int MAX_WIDTH    = lsh_pkg::DEF_MAX_WIDTH,
    parameter int MAX_CHANNELS = lsh_pkg::DEF_MAX_CHANNELS
) (
    input  wire        clk,
    input  wire        rst_n,
    lsh_pix_if.sink    pix_in,
    lsh_out_if.source  sharp_out,
    lsh_cfg_if.sink    cfg
);

    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int NUM_LANES = (MAX_CHANNELS < lsh_pkg::PORT_LANES) ?
                               MAX_CHANNELS : lsh_pkg::PORT_LANES;
    localparam int PIX_W     = lsh_pkg::CHAN_W * NUM_LANES;
    localparam int ROOM_W    = lsh_pkg::OQ_LVL_W + 1;

    logic [lsh_pkg::CFG_W-1:0]      width_reg;
    logic [lsh_pkg::CFG_W-1:0]      height_reg;
    logic [lsh_pkg::CHAN_CNT_W-1:0] chans_reg;
    logic [COL_W-1:0]               col_reg;
    logic [COL_W-1:0]               col_next;
    logic [lsh_pkg::ROW_W-1:0]      row_reg;
    logic [lsh_pkg::ROW_W-1:0]      row_next;
    lsh_pkg::lsh_stage_t            s1_reg;
    lsh_pkg::lsh_stage_t            s1_next;

    logic [COL_W-1:0]               col_last;
    logic [lsh_pkg::ROW_W-1:0]      height_eff;
    logic [lsh_pkg::CHAN_CNT_W-1:0] chans_eff;
    logic                           last_col;
    logic                           in_accept;
    logic                           cfg_accept;
    logic [ROOM_W-1:0]              room_need;
    logic [lsh_pkg::OQ_LVL_W-1:0]   level;

    logic [3*lsh_pkg::CHAN_W-1:0]   px_full;
    logic [PIX_W-1:0]               win_up;
    logic [PIX_W-1:0]               win_left;
    logic [PIX_W-1:0]               win_centre;
    logic [PIX_W-1:0]               win_right;
    logic [PIX_W-1:0]               win_down;
    logic [lsh_pkg::CHAN_W-1:0]     lane_res [lsh_pkg::PORT_LANES];

    lsh_pkg::lsh_push_t             push;
    lsh_pkg::lsh_item_t             item_a;
    lsh_pkg::lsh_item_t             item_b;

    // Effective frame geometry and channel count from the registers.
    always_comb
    begin
        if (width_reg < 12'd3)
        begin
            col_last = COL_W'(2);
        end
        else if (32'(width_reg) >= MAX_WIDTH)
        begin
            col_last = COL_W'(MAX_WIDTH - 1);
        end
        else
        begin
            col_last = COL_W'(32'(width_reg) - 32'd1);
        end

        if (height_reg < 12'd3)
        begin
            height_eff = 12'd3;
        end
        else if (32'(height_reg) > lsh_pkg::MAX_HEIGHT)
        begin
            height_eff = lsh_pkg::ROW_W'(lsh_pkg::MAX_HEIGHT);
        end
        else
        begin
            height_eff = height_reg;
        end

        if (chans_reg == 2'd0)
        begin
            chans_eff = 2'd1;
        end
        else if (32'(chans_reg) > NUM_LANES)
        begin
            chans_eff = lsh_pkg::CHAN_CNT_W'(NUM_LANES);
        end
        else
        begin
            chans_eff = chans_reg;
        end
    end

    assign room_need = ROOM_W'(level) + (s1_reg.valid ? ROOM_W'(2) : ROOM_W'(0))
                     + ROOM_W'(2);
    assign pix_in.ready = (32'(room_need) <= lsh_pkg::OQ_DEPTH);
    assign in_accept    = pix_in.valid && pix_in.ready;
    assign cfg.ready    = 1'b1;
    assign cfg_accept   = cfg.valid && cfg.ready;
    assign last_col     = (col_reg >= col_last);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (in_accept)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = (row_reg >= height_eff) ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end

        s1_next.valid     = in_accept;
        s1_next.emit_a    = (row_reg != '0) && (col_reg != '0);
        s1_next.emit_b    = (row_reg != '0) && (col_reg != '0) && last_col;
        s1_next.interior  = (row_reg >= 12'd2) && (row_reg < height_eff)
                          && (col_reg >= COL_W'(2));
        s1_next.frame_end = (row_reg == height_eff);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= lsh_pkg::RST_IMAGE_WIDTH;
            height_reg <= lsh_pkg::RST_IMAGE_HEIGHT;
            chans_reg  <= lsh_pkg::RST_CHANNEL_COUNT;
            col_reg    <= '0;
            row_reg    <= '0;
            s1_reg     <= '0;
        end
        else
        begin
            s1_reg  <= s1_next;
            col_reg <= col_next;
            row_reg <= row_next;
            if (cfg_accept)
            begin
                case (cfg.index)
                    lsh_pkg::REG_IMAGE_WIDTH:
                    begin
                        width_reg <= cfg.data;
                        col_reg   <= '0;
                        row_reg   <= '0;
                    end
                    lsh_pkg::REG_IMAGE_HEIGHT:
                    begin
                        height_reg <= cfg.data;
                        col_reg    <= '0;
                        row_reg    <= '0;
                    end
                    lsh_pkg::REG_CHANNEL_COUNT:
                    begin
                        chans_reg <= cfg.data[lsh_pkg::CHAN_CNT_W-1:0];
                        col_reg   <= '0;
                        row_reg   <= '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    assign px_full = {pix_in.pixel_chan_c, pix_in.pixel_chan_b, pix_in.pixel_chan_a};

    lsh_line_buf #(
        .MAX_WIDTH (MAX_WIDTH),
        .PIX_W     (PIX_W)
    ) u_line_buf (
        .clk        (clk),
        .rd_en      (in_accept),
        .rd_addr    (col_reg),
        .px_in      (px_full[PIX_W-1:0]),
        .step       (s1_reg.valid),
        .win_up     (win_up),
        .win_left   (win_left),
        .win_centre (win_centre),
        .win_right  (win_right),
        .win_down   (win_down)
    );

    for (genvar k = 0; k < lsh_pkg::PORT_LANES; k++)
    begin : g_lane
        if (k < NUM_LANES)
        begin : g_used
            lsh_lane u_lane (
                .centre (win_centre[k*lsh_pkg::CHAN_W +: lsh_pkg::CHAN_W]),
                .left   (win_left[k*lsh_pkg::CHAN_W +: lsh_pkg::CHAN_W]),
                .right  (win_right[k*lsh_pkg::CHAN_W +: lsh_pkg::CHAN_W]),
                .up     (win_up[k*lsh_pkg::CHAN_W +: lsh_pkg::CHAN_W]),
                .down   (win_down[k*lsh_pkg::CHAN_W +: lsh_pkg::CHAN_W]),
                .en     (s1_reg.interior && (chans_eff > 2'(k))),
                .result (lane_res[k])
            );
        end
        else
        begin : g_unused
            assign lane_res[k] = '0;
        end
    end

    // Merge the lanes into the center result and form the row end result.
    always_comb
    begin
        push.push_a = s1_reg.valid && s1_reg.emit_a;
        push.push_b = s1_reg.valid && s1_reg.emit_b;

        item_a.sharp_chan_a = lane_res[0];
        item_a.sharp_chan_b = lane_res[1];
        item_a.sharp_chan_c = lane_res[2];
        item_a.row_end      = 1'b0;
        item_a.frame_end    = 1'b0;

        item_b.sharp_chan_a = '0;
        item_b.sharp_chan_b = '0;
        item_b.sharp_chan_c = '0;
        item_b.row_end      = 1'b1;
        item_b.frame_end    = s1_reg.frame_end;
    end

    lsh_out_queue u_out_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .item_a (item_a),
        .item_b (item_b),
        .level  (level),
        .out_if (sharp_out)
    );

endmodule

`default_nettype wire

// ----- rtl/lsh_line_buf.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Laplacian sharpening line buffer
// Two previous rows in one memory entry per column, plus the window taps.
// ----------------------------------------------------------------------------
module lsh_line_buf #(
    parameter int MAX_WIDTH = lsh_pkg::DEF_MAX_WIDTH,
    parameter int PIX_W     = 8 * lsh_pkg::DEF_MAX_CHANNELS
) (
    input  wire                          clk,
    input  wire                          rd_en,
    input  wire [$clog2(MAX_WIDTH)-1:0]  rd_addr,
    input  wire [PIX_W-1:0]              px_in,
    input  wire                          step,
    output logic [PIX_W-1:0]             win_up,
    output logic [PIX_W-1:0]             win_left,
    output logic [PIX_W-1:0]             win_centre,
    output logic [PIX_W-1:0]             win_right,
    output logic [PIX_W-1:0]             win_down
);

    localparam int ADDR_W = $clog2(MAX_WIDTH);

    // Each entry holds {older row, newer row} for one column.
    logic [2*PIX_W-1:0]  line_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0]  rd_q_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [PIX_W-1:0]    px_reg;
    logic [PIX_W-1:0]    top_d1_reg;
    logic [PIX_W-1:0]    mid_d1_reg;
    logic [PIX_W-1:0]    mid_d2_reg;
    logic [PIX_W-1:0]    px_d1_reg;
    logic [PIX_W-1:0]    rd_older;
    logic [PIX_W-1:0]    rd_newer;

    assign rd_older = rd_q_reg[2*PIX_W-1:PIX_W];
    assign rd_newer = rd_q_reg[PIX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_q_reg <= line_mem[rd_addr];
            addr_reg <= rd_addr;
            px_reg   <= px_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            line_mem[addr_reg] <= {rd_newer, px_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            top_d1_reg <= rd_older;
            mid_d1_reg <= rd_newer;
            mid_d2_reg <= mid_d1_reg;
            px_d1_reg  <= px_reg;
        end
    end

    assign win_up     = top_d1_reg;
    assign win_left   = mid_d2_reg;
    assign win_centre = mid_d1_reg;
    assign win_right  = rd_newer;
    assign win_down   = px_d1_reg;

endmodule

`default_nettype wire

// ----- rtl/lsh_lane.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Laplacian sharpening lane
// The center scaled by 5 minus its left, right, up and down neighbors, clipped to 0..255; zero while en is low.
// ----------------------------------------------------------------------------
module lsh_lane (
    input  wire [lsh_pkg::CHAN_W-1:0]  centre,
    input  wire [lsh_pkg::CHAN_W-1:0]  left,
    input  wire [lsh_pkg::CHAN_W-1:0]  right,
    input  wire [lsh_pkg::CHAN_W-1:0]  up,
    input  wire [lsh_pkg::CHAN_W-1:0]  down,
    input  wire                        en,
    output logic [lsh_pkg::CHAN_W-1:0] result
);

    logic [11:0] pos_sum;
    logic [11:0] neg_sum;
    logic [11:0] acc;

    always_comb
    begin
        pos_sum = {2'b00, centre, 2'b00} + {4'b0000, centre};
        neg_sum = {4'b0000, left} + {4'b0000, right} + {4'b0000, up}
                + {4'b0000, down};
        acc     = pos_sum - neg_sum;
        if (!en || acc[11])
        begin
            result = '0;
        end
        else if (acc[10:8] != 3'b000)
        begin
            result = '1;
        end
        else
        begin
            result = acc[7:0];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/lsh_out_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Laplacian sharpening output queue
// Takes up to two results per cycle and hands them out one per request.
// ----------------------------------------------------------------------------
module lsh_out_queue (
    input  wire                               clk,
    input  wire                               rst_n,
    input  lsh_pkg::lsh_push_t                push,
    input  lsh_pkg::lsh_item_t                item_a,
    input  lsh_pkg::lsh_item_t                item_b,
    output logic [lsh_pkg::OQ_LVL_W-1:0]      level,
    lsh_out_if.source                         out_if
);

    lsh_pkg::lsh_item_t                 queue_mem [lsh_pkg::OQ_DEPTH];
    lsh_pkg::lsh_item_t                 first_item;
    lsh_pkg::lsh_item_t                 head;
    logic [lsh_pkg::OQ_PTR_W-1:0]       wr_reg;
    logic [lsh_pkg::OQ_PTR_W-1:0]       wr_next;
    logic [lsh_pkg::OQ_PTR_W-1:0]       rd_reg;
    logic [lsh_pkg::OQ_PTR_W-1:0]       rd_next;
    logic [lsh_pkg::OQ_LVL_W-1:0]       lvl_reg;
    logic [lsh_pkg::OQ_LVL_W-1:0]       lvl_next;
    logic [1:0]                         n_push;
    logic                               pop;

    always_comb
    begin
        n_push     = {1'b0, push.push_a} + {1'b0, push.push_b};
        first_item = push.push_a ? item_a : item_b;
        pop        = out_if.valid && out_if.ready;
        wr_next    = wr_reg + lsh_pkg::OQ_PTR_W'(n_push);
        rd_next    = rd_reg + lsh_pkg::OQ_PTR_W'(pop);
        lvl_next   = lvl_reg + lsh_pkg::OQ_LVL_W'(n_push)
                   - lsh_pkg::OQ_LVL_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0)
        begin
            queue_mem[wr_reg] <= first_item;
        end
        if (n_push == 2'd2)
        begin
            queue_mem[lsh_pkg::OQ_PTR_W'(wr_reg + 1'b1)] <= item_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            lvl_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            lvl_reg <= lvl_next;
        end
    end

    assign head                = queue_mem[rd_reg];
    assign level               = lvl_reg;
    assign out_if.valid        = (lvl_reg != '0);
    assign out_if.sharp_chan_a = head.sharp_chan_a;
    assign out_if.sharp_chan_b = head.sharp_chan_b;
    assign out_if.sharp_chan_c = head.sharp_chan_c;
    assign out_if.row_end      = head.row_end;
    assign out_if.frame_end    = head.frame_end;

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the 3x3 Laplacian sharpening filter
// Streams frames of raster pixels through the filter under random input gaps
// and output back-pressure, predicts every sharpened pixel with a behavioral
// copy of the line buffers and window, and compares each result field by
// field. Register writes cover clamped, extreme and ignored settings.
// ----------------------------------------------------------------------------
module testbench;

    localparam int LINE_LEN      = lsh_pkg::DEF_MAX_WIDTH;
    localparam int SMALL_ITEMS   = 1200;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 5000;
    localparam int HOLD_CYCLES   = 400;

    typedef logic [3*lsh_pkg::CHAN_W-1:0] pixel_word_t;
    typedef enum int {PAT_NOISE, PAT_SMOOTH, PAT_BINARY} pattern_t;

    logic clk = 1'b0;
    logic rst_n;

    lsh_pix_if pix_bus();
    lsh_out_if sharp_bus();
    lsh_cfg_if cfg_bus();

    laplacian_sharpen_3x3_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_in    (pix_bus),
        .sharp_out (sharp_bus),
        .cfg       (cfg_bus)
    );

    pixel_word_t          pixels_to_send[$];
    lsh_pkg::lsh_item_t   expected_sharp[$];

    logic [lsh_pkg::CFG_W-1:0]      shadow_width;
    logic [lsh_pkg::CFG_W-1:0]      shadow_height;
    logic [lsh_pkg::CHAN_CNT_W-1:0] shadow_chans;
    pixel_word_t                    older_line [0:LINE_LEN-1];
    pixel_word_t                    newer_line [0:LINE_LEN-1];
    pixel_word_t                    kernel_win [0:8];
    int unsigned                    next_col;
    int unsigned                    next_row;

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned recv_hold     = 0;
    int unsigned stall_cycles  = 0;
    int unsigned mismatches    = 0;
    int unsigned pixels_queued = 0;
    bit          pix_taken     = 1'b0;
    bit          out_taken     = 1'b0;
    bit          cfg_taken     = 1'b0;
    pixel_word_t next_px;

    always #5 clk = ~clk;

    function automatic int unsigned active_width();
        int unsigned w;
        w = 32'(shadow_width);
        if (w < 3) w = 3;
        if (w > LINE_LEN) w = LINE_LEN;
        return w;
    endfunction

    function automatic int unsigned active_height();
        int unsigned h;
        h = 32'(shadow_height);
        if (h < 3) h = 3;
        if (h > lsh_pkg::MAX_HEIGHT) h = lsh_pkg::MAX_HEIGHT;
        return h;
    endfunction

    function automatic lsh_pkg::lsh_item_t window_result(input int unsigned orow,
                                                         input int unsigned ocol,
                                                         input bit use_win,
                                                         input int unsigned w,
                                                         input int unsigned h);
        lsh_pkg::lsh_item_t res;
        bit                 interior;
        int unsigned        nch;
        int                 s;
        logic [7:0]         v [0:2];
        nch = (shadow_chans == 0) ? 1 : 32'(shadow_chans);
        interior = use_win && orow >= 1 && orow + 2 <= h && ocol >= 1 && ocol + 2 <= w;
        for (int k = 0; k < 3; k++)
        begin
            s = 5 * int'(kernel_win[4][8*k +: 8]) - int'(kernel_win[3][8*k +: 8])
                - int'(kernel_win[5][8*k +: 8]) - int'(kernel_win[1][8*k +: 8])
                - int'(kernel_win[7][8*k +: 8]);
            if (s < 0) s = 0;
            if (s > 255) s = 255;
            v[k] = (interior && k < nch) ? s[7:0] : 8'd0;
        end
        res.sharp_chan_a = v[0];
        res.sharp_chan_b = v[1];
        res.sharp_chan_c = v[2];
        res.row_end      = (ocol + 1 == w);
        res.frame_end    = (ocol + 1 == w) && (orow + 1 == h);
        return res;
    endfunction

    task automatic sharpen_pixel(input pixel_word_t px);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        pixel_word_t top;
        pixel_word_t mid;
        w = active_width();
        h = active_height();
        c = next_col;
        r = next_row;
        if (c >= w) c = w - 1;
        if (r > h) r = h;
        top = older_line[c];
        mid = newer_line[c];
        older_line[c] = mid;
        newer_line[c] = px;
        kernel_win[0] = kernel_win[1]; kernel_win[1] = kernel_win[2]; kernel_win[2] = top;
        kernel_win[3] = kernel_win[4]; kernel_win[4] = kernel_win[5]; kernel_win[5] = mid;
        kernel_win[6] = kernel_win[7]; kernel_win[7] = kernel_win[8]; kernel_win[8] = px;
        if (r >= 1 && c >= 1)
        begin
            expected_sharp.push_back(window_result(r - 1, c - 1, 1'b1, w, h));
            if (c + 1 == w) expected_sharp.push_back(window_result(r - 1, c, 1'b0, w, h));
        end
        if (c + 1 >= w)
        begin
            next_col = 0;
            next_row = (r >= h) ? 0 : r + 1;
        end
        else
        begin
            next_col = c + 1;
            next_row = r;
        end
    endtask

    task automatic apply_register(input logic [lsh_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [lsh_pkg::CFG_W-1:0] value);
        if (idx == lsh_pkg::REG_IMAGE_WIDTH) shadow_width = value;
        else if (idx == lsh_pkg::REG_IMAGE_HEIGHT) shadow_height = value;
        else if (idx == lsh_pkg::REG_CHANNEL_COUNT)
            shadow_chans = value[lsh_pkg::CHAN_CNT_W-1:0];
        else return;
        next_col = 0;
        next_row = 0;
    endtask

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    task automatic check_result();
        lsh_pkg::lsh_item_t want;
        if (expected_sharp.size() == 0)
        begin
            $error("sharpened pixel %0d/%0d/%0d with none predicted", sharp_bus.sharp_chan_a,
                   sharp_bus.sharp_chan_b, sharp_bus.sharp_chan_c);
            mismatches++;
            return;
        end
        want = expected_sharp.pop_front();
        check_field("sharp_chan_a", 32'(want.sharp_chan_a), 32'(sharp_bus.sharp_chan_a));
        check_field("sharp_chan_b", 32'(want.sharp_chan_b), 32'(sharp_bus.sharp_chan_b));
        check_field("sharp_chan_c", 32'(want.sharp_chan_c), 32'(sharp_bus.sharp_chan_c));
        check_field("row_end", 32'(want.row_end), 32'(sharp_bus.row_end));
        check_field("frame_end", 32'(want.frame_end), 32'(sharp_bus.frame_end));
    endtask

    always @(posedge clk)
    begin
        pix_taken = pix_bus.valid && pix_bus.ready;
        out_taken = sharp_bus.valid && sharp_bus.ready;
        cfg_taken = cfg_bus.valid && cfg_bus.ready;
        if (rst_n)
        begin
            if (cfg_taken) apply_register(cfg_bus.index, cfg_bus.data);
            if (pix_taken)
                sharpen_pixel({pix_bus.pixel_chan_c, pix_bus.pixel_chan_b, pix_bus.pixel_chan_a});
            if (out_taken) check_result();
            if (pix_taken || out_taken || cfg_taken) stall_cycles = 0;
            else stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // A pixel request stays up until it is taken.
    always @(negedge clk)
    begin
        if (rst_n && (!pix_bus.valid || pix_taken))
        begin
            if (pixels_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                next_px = pixels_to_send.pop_front();
                pix_bus.valid        <= 1'b1;
                pix_bus.pixel_chan_a <= next_px[7:0];
                pix_bus.pixel_chan_b <= next_px[15:8];
                pix_bus.pixel_chan_c <= next_px[23:16];
            end
            else
            begin
                pix_bus.valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (recv_hold != 0) recv_hold = recv_hold - 1;
        sharp_bus.ready <= (recv_hold == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
    end

    task automatic wait_until_drained();
        while (pixels_to_send.size() != 0 || pix_bus.valid || expected_sharp.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [lsh_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [lsh_pkg::CFG_W-1:0] value);
        wait_until_drained();
        @(negedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        @(posedge clk);
        while (!cfg_bus.ready) @(posedge clk);
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic queue_pixels(input int unsigned count);
        pattern_t    pat;
        int          base [0:2];
        int          v;
        pixel_word_t px;
        pat = pattern_t'($urandom_range(0, 2));
        for (int k = 0; k < 3; k++) base[k] = int'($urandom_range(0, 255));
        for (int unsigned i = 0; i < count; i++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                case (pat)
                    PAT_SMOOTH:
                    begin
                        v = base[k] + int'($urandom_range(0, 24)) - 12;
                        if (v < 0) v = 0;
                        if (v > 255) v = 255;
                    end
                    PAT_BINARY: v = $urandom_range(0, 1) ? 255 : 0;
                    default:    v = int'($urandom_range(0, 255));
                endcase
                px[8*k +: 8] = v[7:0];
            end
            pixels_to_send.push_back(px);
            pixels_queued++;
        end
    endtask

    function automatic pixel_word_t test_card(input int r, input int c);
        if (r == 3) return '1;
        if (r == 1 && c == 1) return {8'd100, 8'd0, 8'd255};
        if ((r == 1) != (c == 1)) return {8'(50 + 10 * (r * 3 + c)), 8'hFF, 8'h00};
        return {8'hA5, 8'h5A, 8'h3C};
    endfunction

    initial
    begin
        int unsigned full;
        int unsigned part;
        int unsigned frames;
        int unsigned roll;
        rst_n = 1'b0;
        pix_bus.valid = 1'b0;
        pix_bus.pixel_chan_a = '0;
        pix_bus.pixel_chan_b = '0;
        pix_bus.pixel_chan_c = '0;
        sharp_bus.ready = 1'b0;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = '0;
        cfg_bus.data = '0;
        shadow_width  = lsh_pkg::RST_IMAGE_WIDTH;
        shadow_height = lsh_pkg::RST_IMAGE_HEIGHT;
        shadow_chans  = lsh_pkg::RST_CHANNEL_COUNT;
        for (int i = 0; i < LINE_LEN; i++)
        begin
            older_line[i] = '0;
            newer_line[i] = '0;
        end
        for (int i = 0; i < 9; i++) kernel_win[i] = '0;
        next_col = 0;
        next_row = 0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        send_idle_pct = 28;
        recv_idle_pct = 63;
        write_register(lsh_pkg::REG_IMAGE_WIDTH, 12'd0);
        write_register(lsh_pkg::REG_IMAGE_HEIGHT, 12'd2);
        write_register(lsh_pkg::REG_CHANNEL_COUNT, 12'd3);
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 3; c++) pixels_to_send.push_back(test_card(r, c));
        recv_hold = HOLD_CYCLES;
        write_register(lsh_pkg::REG_CHANNEL_COUNT, 12'hFFC);
        for (int i = 0; i < 12; i++)
        begin
            pixels_to_send.push_back(test_card(i / 3, i % 3));
            if (i == 5)
            begin
                wait_until_drained();
                write_register({lsh_pkg::CFG_IDX_W{1'b1}}, '1);
            end
        end

        pixels_queued = 0;
        while (pixels_queued < SMALL_ITEMS)
        begin
            if (pixels_queued < SMALL_ITEMS / 3)
            begin
                send_idle_pct = 28;
                recv_idle_pct = 63;
            end
            else if (pixels_queued < 2 * SMALL_ITEMS / 3)
            begin
                send_idle_pct = 63;
                recv_idle_pct = 28;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_register(lsh_pkg::REG_IMAGE_WIDTH, lsh_pkg::CFG_W'($urandom_range(0, 12)));
            if ($urandom_range(0, 2) != 0)
                write_register(lsh_pkg::REG_IMAGE_HEIGHT,
                               lsh_pkg::CFG_W'($urandom_range(0, 8)));
            if ($urandom_range(0, 2) != 0)
                write_register(lsh_pkg::REG_CHANNEL_COUNT,
                               lsh_pkg::CFG_W'(($urandom & 32'hFFC) | $urandom_range(0, 3)));
            frames = $urandom_range(1, 3);
            for (int f = 0; f < frames; f++)
            begin
                full = active_width() * (active_height() + 1);
                roll = $urandom_range(0, 9);
                if (roll == 0)
                begin
                    queue_pixels($urandom_range(1, full - 1));
                    break;
                end
                else if (roll == 1)
                begin
                    part = $urandom_range(1, full - 1);
                    queue_pixels(part);
                    write_register(lsh_pkg::CFG_IDX_W'($urandom_range(
                                       32'(lsh_pkg::REG_CHANNEL_COUNT) + 1,
                                       (1 << lsh_pkg::CFG_IDX_W) - 1)),
                                   lsh_pkg::CFG_W'($urandom));
                    queue_pixels(full - part);
                end
                else
                begin
                    queue_pixels(full);
                end
            end
        end

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_register(lsh_pkg::REG_IMAGE_WIDTH, 12'd2048);
        write_register(lsh_pkg::REG_IMAGE_HEIGHT, 12'd3);
        write_register(lsh_pkg::REG_CHANNEL_COUNT, 12'd3);
        queue_pixels(256);
        write_register(lsh_pkg::REG_IMAGE_WIDTH, 12'hFFF);
        queue_pixels(128);
        write_register(lsh_pkg::REG_IMAGE_WIDTH, 12'd3);
        write_register(lsh_pkg::REG_IMAGE_HEIGHT, 12'hFFF);
        queue_pixels(20 * active_width());
        write_register(lsh_pkg::REG_IMAGE_HEIGHT, 12'd2048);
        queue_pixels(3 * active_width());

        wait_until_drained();
        if (mismatches == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/lsh_pkg.sv
rtl/lsh_ifs.sv
rtl/lsh_line_buf.sv
rtl/lsh_lane.sv
rtl/lsh_out_queue.sv
rtl/laplacian_sharpen_3x3_top.sv
tb/testbench.sv
